// ===== src/pasv_pkg.sv =====
package pasv_pkg;

  localparam logic [7:0] ChOpen  = 8'h28;
  localparam logic [7:0] ChClose = 8'h29;
  localparam logic [7:0] ChComma = 8'h2c;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  localparam int unsigned NumMax   = 255;
  localparam int unsigned NumSat   = 256;
  localparam int unsigned NumCount = 6;
  localparam int unsigned NumBase  = 10;

  localparam logic [2:0] LastIndex = 3'(NumCount - 1);
  localparam logic [2:0] PortHiIdx = 3'd4;
  localparam logic [8:0] SatValue  = 9'(NumSat);
  localparam logic [8:0] MaxValue  = 9'(NumMax);

  typedef enum logic [5:0] {
    PH_SEARCH    = 6'b000001,
    PH_PRE_NUM   = 6'b000010,
    PH_IN_NUM    = 6'b000100,
    PH_PRE_CLOSE = 6'b001000,
    PH_AFTER     = 6'b010000,
    PH_BAD       = 6'b100000
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [2:0]  number_index;
    logic [8:0]  digit_value;
    logic [31:0] address_acc;
    logic [15:0] port_acc;
  } parse_state_t;

  localparam parse_state_t StateReset = '{
    phase:        PH_SEARCH,
    number_index: 3'd0,
    digit_value:  9'd0,
    address_acc:  32'd0,
    port_acc:     16'd0
  };

endpackage

// ===== src/pasv_if.sv =====
interface pasv_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink (input valid, input text_byte, input final_byte, output ready);
endinterface

interface pasv_result_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [31:0] host_address;
  logic [15:0] port_number;

  modport source (output valid, output status, output host_address, output port_number,
                  input ready);
  modport sink (input valid, input status, input host_address, input port_number,
                output ready);
endinterface

// ===== src/pasv_parse_step.sv =====
module pasv_parse_step (
  input  pasv_pkg::parse_state_t st,
  input  logic [7:0]             text_byte,
  output pasv_pkg::parse_state_t st_next
);
  import pasv_pkg::*;

  logic        is_digit;
  logic        is_blank;
  logic        is_space_any;
  logic [3:0]  digit;
  logic [11:0] acc_wide;
  logic        num_ok;
  parse_state_t fin;

  assign is_digit     = (text_byte >= ChZero) && (text_byte <= ChNine);
  assign is_blank     = (text_byte == ChSpace) || (text_byte == ChTab);
  assign is_space_any = is_blank || (text_byte == ChCr) || (text_byte == ChLf);
  assign digit        = text_byte[3:0];
  assign acc_wide     = 12'(st.digit_value) * 12'(NumBase) + 12'(digit);
  assign num_ok       = st.digit_value <= MaxValue;

  // state after closing the current number
  always_comb begin
    fin = st;
    fin.digit_value = 9'd0;
    if (st.number_index < PortHiIdx) begin
      fin.address_acc = {st.address_acc[23:0], st.digit_value[7:0]};
    end else if (st.number_index == PortHiIdx) begin
      fin.port_acc = {st.digit_value[7:0], 8'd0};
    end else begin
      fin.port_acc = {st.port_acc[15:8], st.digit_value[7:0]};
    end
  end

  always_comb begin
    st_next = st;
    unique case (st.phase)
      PH_SEARCH: begin
        if (text_byte == ChOpen) st_next.phase = PH_PRE_NUM;
      end
      PH_PRE_NUM: begin
        if (is_digit) begin
          st_next.digit_value = 9'(digit);
          st_next.phase = PH_IN_NUM;
        end else if (!is_blank) begin
          st_next.phase = PH_BAD;
        end
      end
      PH_IN_NUM: begin
        if (is_digit) begin
          st_next.digit_value = (acc_wide > 12'(NumSat)) ? SatValue : acc_wide[8:0];
        end else if (st.number_index < LastIndex) begin
          if (text_byte == ChComma && num_ok) begin
            st_next = fin;
            st_next.number_index = st.number_index + 3'd1;
            st_next.phase = PH_PRE_NUM;
          end else begin
            st_next.phase = PH_BAD;
          end
        end else begin
          if (text_byte == ChClose && num_ok) begin
            st_next = fin;
            st_next.phase = PH_AFTER;
          end else if (is_space_any && num_ok) begin
            st_next = fin;
            st_next.phase = PH_PRE_CLOSE;
          end else begin
            st_next.phase = PH_BAD;
          end
        end
      end
      PH_PRE_CLOSE: begin
        if (text_byte == ChClose) st_next.phase = PH_AFTER;
        else if (!is_space_any) st_next.phase = PH_BAD;
      end
      PH_AFTER: begin
        if (!is_space_any) st_next.phase = PH_BAD;
      end
      default: st_next.phase = PH_BAD;
    endcase
  end

endmodule

// ===== src/pasv_reply_address_parser.sv =====
// Parses the text of a passive-mode reply, one character per beat on the text
// channel, and gives one result beat after the beat flagged final_byte: status 0
// with the host address and port, or status 1 with both zero when the text is
// malformed. The parse state is updated from the accepted beat by one step of
// logic, and the result sits in an output register, so text is taken every cycle
// unless a result is waiting and the result side is stalled. After a final beat
// the parser starts fresh on the next text.
module pasv_reply_address_parser (
  input  logic                 clk,
  input  logic                 rst,
  pasv_text_if.sink            text,
  pasv_result_if.source        result
);
  import pasv_pkg::*;

  parse_state_t st;
  parse_state_t st_next;
  logic         text_accept;
  logic         ok;

  pasv_parse_step u_step (
    .st        (st),
    .text_byte (text.text_byte),
    .st_next   (st_next)
  );

  assign text.ready  = !result.valid || result.ready;
  assign text_accept = text.valid && text.ready;
  assign ok          = st_next.phase == PH_AFTER;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= StateReset;
      result.valid <= 1'b0;
    end else begin
      if (text_accept && text.final_byte) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      if (text_accept) begin
        if (text.final_byte) begin
          st <= StateReset;
        end else begin
          st <= st_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (text_accept && text.final_byte) begin
      result.status       <= !ok;
      result.host_address <= ok ? st_next.address_acc : 32'd0;
      result.port_number  <= ok ? st_next.port_acc : 16'd0;
    end
  end

  a_final_gives_result: assert property (@(posedge clk) disable iff (rst)
    text_accept && text.final_byte |=> result.valid)
    else $error("final beat gave no result");

  a_no_result_midtext: assert property (@(posedge clk) disable iff (rst)
    text_accept && !text.final_byte |=> !$rose(result.valid))
    else $error("result without final beat");

  a_restart_after_final: assert property (@(posedge clk) disable iff (rst)
    text_accept && text.final_byte |=> st.phase == PH_SEARCH && st.number_index == 3'd0)
    else $error("parser not restarted after final beat");

  a_bad_is_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.status |-> result.host_address == 32'd0 &&
      result.port_number == 16'd0)
    else $error("malformed result carries data");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    st.number_index <= LastIndex)
    else $error("number index out of range");

endmodule
